FILE: rtl/bfa_pkg.sv
`timescale 1ns / 1ps

package bfa_pkg;

	localparam int FRAME_W = 20;
	localparam int COUNT_W = 13;

	localparam int MAX_FRAMES_DEF = 4096;
	localparam int WORD_BITS_DEF  = 64;
	localparam int POOL_FRAMES_RST = 4096;

	// request codes
	typedef logic [1:0] req_t;
	localparam req_t REQ_ALLOC   = 2'd0;
	localparam req_t REQ_RELEASE = 2'd1;
	localparam req_t REQ_MARK    = 2'd2;

	// status codes
	typedef logic [1:0] status_t;
	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_FULL  = 2'd1;
	localparam status_t STAT_RANGE = 2'd2;

	// configuration register indexes
	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_POOL_BASE   = 1'd0;
	localparam cfg_idx_t CFG_POOL_FRAMES = 1'd1;

endpackage

FILE: rtl/bfa_ram.sv
`timescale 1ns / 1ps

module bfa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/bfa_word_unit.sv
`timescale 1ns / 1ps

module bfa_word_unit #(
	parameter int WORD_BITS = 64,
	parameter int XW = 17,
	localparam int BW = $clog2(WORD_BITS),
	localparam int RW = $clog2(WORD_BITS + 1)
) (
	input  bfa_pkg::req_t        op,
	input  logic [XW-1:0]        word_base,
	input  logic [XW-1:0]        lo,
	input  logic [XW-1:0]        hi,
	input  logic [WORD_BITS-1:0] rd_word,
	output logic [WORD_BITS-1:0] wr_word,
	output logic                 hit,
	output logic [BW-1:0]        hit_pos
);
	import bfa_pkg::*;

	logic [XW-1:0]        lo_d;
	logic [XW-1:0]        hi_d;
	logic [RW-1:0]        lo_c;
	logic [RW-1:0]        hi_c;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] avail;
	logic [WORD_BITS-1:0] first;

	// range bounds relative to this word, clamped to the word
	assign lo_d = lo - word_base;
	assign hi_d = hi - word_base;

	always_comb begin
		if (lo <= word_base) begin
			lo_c = '0;
		end else if (lo_d >= XW'(WORD_BITS)) begin
			lo_c = RW'(WORD_BITS);
		end else begin
			lo_c = RW'(lo_d);
		end
		if (hi <= word_base) begin
			hi_c = '0;
		end else if (hi_d >= XW'(WORD_BITS)) begin
			hi_c = RW'(WORD_BITS);
		end else begin
			hi_c = RW'(hi_d);
		end
	end

	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			mask[j] = (RW'(j) >= lo_c) && (RW'(j) < hi_c);
		end
	end

	// lowest free bit inside the range
	assign avail = ~rd_word & mask;
	assign first = avail & (~avail + WORD_BITS'(1));
	assign hit   = |avail;

	always_comb begin
		hit_pos = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (avail[j]) begin
				hit_pos = BW'(j);
			end
		end
	end

	always_comb begin
		case (op)
			REQ_ALLOC:   wr_word = rd_word | first;
			REQ_RELEASE: wr_word = rd_word & ~mask;
			REQ_MARK:    wr_word = rd_word | mask;
			default:     wr_word = rd_word;
		endcase
	end

endmodule

FILE: rtl/bitmap_frame_allocator.sv
`timescale 1ns / 1ps
// done is registered: requests answered at once (out of range, empty mark, unknown type)
//   strobe it in the cycle after start; the others step through S_READ, then S_EVAL per word visited
// throughput: one request at a time; allocate walks the bitmap memory in a single
//   read-modify-write pass, one word per cycle
// reset: clears the sequencer and config registers, then sweeps every bitmap word to zero
// results are strobed on done for one cycle; the receiver cannot stall
module bitmap_frame_allocator #(
	parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF,
	parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_we,
	input  bfa_pkg::cfg_idx_t         cfg_index,
	input  logic [bfa_pkg::FRAME_W-1:0] cfg_data,
	// request
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                req_type,
	input  logic [bfa_pkg::FRAME_W-1:0] frame_number,
	input  logic [bfa_pkg::COUNT_W-1:0] range_count,
	// result
	output logic                      done,
	output logic [bfa_pkg::FRAME_W-1:0] granted_frame,
	output logic [1:0]                status
);
	import bfa_pkg::*;

	localparam int NWORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int LIM    = NWORDS * WORD_BITS;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int BW     = $clog2(WORD_BITS);
	// frame index width, wide enough for a word base stepped one word past the end
	localparam int XW     = $clog2(LIM + WORD_BITS + 1);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_READ  = 4'b0100,
		S_EVAL  = 4'b1000
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        clr_q;
	logic [AW-1:0]        wa_q;
	logic [XW-1:0]        wbase_q;
	logic [XW-1:0]        lo_q;
	logic [XW-1:0]        hi_q;
	req_t                 req_q;
	logic                 done_q;
	logic [FRAME_W-1:0]   granted_q;
	status_t              status_q;
	logic [FRAME_W-1:0]   pool_base_q;
	logic [COUNT_W-1:0]   pool_frames_q;

	// pool geometry
	logic [XW-1:0]        pool_n;
	logic [FRAME_W-1:0]   off_raw;
	logic                 in_pool;
	logic [XW-1:0]        off;
	logic [XW-1:0]        room;
	logic [XW-1:0]        mark_end;
	logic                 accept;

	// bitmap memory ports
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	// word unit
	logic [WORD_BITS-1:0] unit_word;
	logic                 unit_hit;
	logic [BW-1:0]        unit_pos;
	logic                 last_word;
	logic [XW-1:0]        hit_idx;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q   <= '0;
			pool_frames_q <= COUNT_W'(POOL_FRAMES_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POOL_BASE:   pool_base_q   <= cfg_data;
				CFG_POOL_FRAMES: pool_frames_q <= cfg_data[COUNT_W-1:0];
				default:         ;
			endcase
		end
	end

	// pool size clipped to capacity
	assign pool_n = (32'(pool_frames_q) > 32'(MAX_FRAMES)) ? XW'(MAX_FRAMES)
	                                                     : XW'(pool_frames_q);

	// offset of the requested frame inside the pool
	assign off_raw = frame_number - pool_base_q;
	assign in_pool = (frame_number >= pool_base_q) && (32'(off_raw) < 32'(pool_n));
	assign off     = XW'(off_raw);

	// mark run end, clipped at the pool end
	assign room     = pool_n - off;
	assign mark_end = (32'(range_count) < 32'(room)) ? off + XW'(range_count) : pool_n;

	assign accept = start && state_q == S_IDLE;
	assign busy   = state_q != S_IDLE;

	// word walk is finished once the range ends inside the current word
	assign last_word = 32'(hi_q) <= 32'(wbase_q) + 32'(WORD_BITS);
	assign hit_idx   = wbase_q + XW'(unit_pos);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NWORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (req_type)
							REQ_ALLOC: begin
								state_q <= S_READ;
							end
							REQ_RELEASE: begin
								if (in_pool) begin
									state_q <= S_READ;
								end else begin
									done_q <= 1'b1;
								end
							end
							REQ_MARK: begin
								if (in_pool && range_count != '0) begin
									state_q <= S_READ;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if ((req_q == REQ_ALLOC && unit_hit) || last_word) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request context and result word
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req_type;
			wa_q      <= '0;
			wbase_q   <= '0;
			granted_q <= '0;
			status_q  <= STAT_OK;
			case (req_type)
				REQ_ALLOC: begin
					lo_q <= '0;
					hi_q <= pool_n;
				end
				REQ_RELEASE: begin
					lo_q <= off;
					hi_q <= off + XW'(1);
					if (!in_pool) begin
						status_q <= STAT_RANGE;
					end
				end
				REQ_MARK: begin
					lo_q <= off;
					hi_q <= mark_end;
					if (!in_pool) begin
						status_q <= STAT_RANGE;
					end
				end
				default: begin
					lo_q <= '0;
					hi_q <= '0;
				end
			endcase
		end else if (state_q == S_EVAL) begin
			wa_q    <= wa_q + AW'(1);
			wbase_q <= wbase_q + XW'(WORD_BITS);
			if (req_q == REQ_ALLOC) begin
				if (unit_hit) begin
					granted_q <= pool_base_q + FRAME_W'(hit_idx);
				end else if (last_word) begin
					status_q <= STAT_FULL;
				end
			end
		end
	end

	// memory read runs one word ahead while walking
	assign ram_raddr = (state_q == S_EVAL) ? wa_q + AW'(1) : wa_q;
	assign ram_we    = (state_q == S_CLEAR) || (state_q == S_EVAL);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : wa_q;
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : unit_word;

	bfa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NWORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bfa_word_unit #(
		.WORD_BITS (WORD_BITS),
		.XW        (XW)
	) u_word (
		.op        (req_q),
		.word_base (wbase_q),
		.lo        (lo_q),
		.hi        (hi_q),
		.rd_word   (ram_rdata),
		.wr_word   (unit_word),
		.hit       (unit_hit),
		.hit_pos   (unit_pos)
	);

	assign done          = done_q;
	assign granted_frame = granted_q;
	assign status        = status_q;

endmodule
